### rtl/core/skla_pkg.sv
// Shared types, constants and the log2 fraction table builder for the
// symmetric KL divergence accumulator. No dependencies.
package skla_pkg;

    localparam int PROB_BITS_DEF      = 16;
    localparam int LOG_TABLE_BITS_DEF = 8;
    localparam int FRAC_BITS          = 16;
    localparam int TAB_W              = FRAC_BITS + 1;
    localparam int ACC_W              = 48;
    localparam int OUT_W              = 32;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Per-stage control that travels alongside the pipeline payload
    typedef struct packed {
        logic valid;
        logic last;
        logic p_nz;
        logic q_nz;
    } stage_ctl_t;

    // Finished sums handed from the accumulator to the result stage
    typedef struct packed {
        logic signed [ACC_W-1:0] fwd;
        logic signed [ACC_W-1:0] bwd;
        logic                    ovf;
    } sums_t;

    // Width of a signed Q16 log2 value for a given probability format
    function automatic int log_width(input int prob_bits);
        return $clog2(prob_bits + 1) + 1 + FRAC_BITS;
    endfunction

    // round(log2(1 + idx/2^tbits)) in Q16, by repeated squaring of a Q1.31
    // mantissa; evaluated at elaboration only
    function automatic logic [TAB_W-1:0] frac_entry(input int idx, input int tbits);
        logic [63:0] m;
        logic [63:0] r;
        logic [31:0] v;
        logic [31:0] rounded;
        m = (64'(1 << tbits) + 64'(idx)) << (31 - tbits);
        v = '0;
        for (int k = 0; k < 24; k++)
        begin
            r = (m * m) >> 31;
            v = v << 1;
            if (r >= 64'h1_0000_0000)
            begin
                v = v | 32'd1;
                r = r >> 1;
            end
            m = r;
        end
        rounded = (v + 32'd128) >> 8;
        return rounded[TAB_W-1:0];
    endfunction

endpackage

### rtl/core/skla_if.sv
// Valid/ready channel interfaces for probability pair words and result words.
// Depends on skla_pkg.
interface skla_in_if import skla_pkg::*; #(
    parameter int PROB_BITS = PROB_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [PROB_BITS:0] p_value;
    logic [PROB_BITS:0] q_value;
    logic               last_item;

    modport source (output valid, output p_value, output q_value, output last_item,
                    input ready);
    modport sink   (input valid, input p_value, input q_value, input last_item,
                    output ready);
endinterface

interface skla_out_if import skla_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] kl_forward;
    logic [OUT_W-1:0] kl_backward;
    logic [OUT_W-1:0] kl_symmetric;
    logic             saturated;

    modport source (output valid, output kl_forward, output kl_backward,
                    output kl_symmetric, output saturated, input ready);
    modport sink   (input valid, input kl_forward, input kl_backward,
                    input kl_symmetric, input saturated, output ready);
endinterface

### rtl/core/skla_log2.sv
// Table-based log2 of a fixed point probability, Q16 result.
// Depends on skla_pkg (fraction table builder, widths).
module skla_log2 import skla_pkg::*; #(
    parameter int PROB_BITS      = PROB_BITS_DEF,
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
    input  logic [PROB_BITS:0]                 x,
    output logic signed [log_width(PROB_BITS)-1:0] log_val
);
    localparam int LOG_W    = log_width(PROB_BITS);
    localparam int E_W      = $clog2(PROB_BITS + 1);
    localparam int EXP_W    = E_W + 1;
    localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;
    localparam int N_W      = PROB_BITS + 1 + LOG_TABLE_BITS;

    logic [TAB_W-1:0]          tab [TAB_SIZE];
    logic [E_W-1:0]            lead;
    logic [E_W-1:0]            shamt;
    logic [N_W-1:0]            norm;
    logic [LOG_TABLE_BITS-1:0] idx;
    logic signed [EXP_W-1:0]   int_part;

    for (genvar i = 0; i < TAB_SIZE; i++)
    begin : g_tab
        localparam logic [TAB_W-1:0] ENTRY = frac_entry(i, LOG_TABLE_BITS);
        assign tab[i] = ENTRY;
    end

    // leading one; a zero word falls through to bit 0
    always_comb
    begin
        lead = '0;
        for (int b = 1; b <= PROB_BITS; b++)
        begin
            if (x[b])
                lead = E_W'(b);
        end
    end

    // bring the leading one up to a fixed place: bits below it form the index,
    // zero filled where the word is short
    assign shamt    = E_W'(PROB_BITS) - lead;
    assign norm     = {x, {LOG_TABLE_BITS{1'b0}}} << shamt;
    assign idx      = norm[PROB_BITS+LOG_TABLE_BITS-1 -: LOG_TABLE_BITS];
    assign int_part = $signed({1'b0, lead}) - $signed(EXP_W'(PROB_BITS));
    assign log_val  = $signed({int_part, {FRAC_BITS{1'b0}}} + LOG_W'(tab[idx]));

endmodule

### rtl/core/skla_accum.sv
// Saturating forward and backward accumulators with the hand-off register
// for finished sums. Depends on skla_pkg.
module skla_accum import skla_pkg::*; #(
    parameter int TERM_W = 25
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  stage_ctl_t               ctl,
    input  logic signed [TERM_W-1:0] term_f,
    input  logic signed [TERM_W-1:0] term_b,
    input  logic                     fin_take,
    output logic                     fin_valid,
    output sums_t                    fin
);
    logic signed [ACC_W-1:0] fwd_reg, fwd_next;
    logic signed [ACC_W-1:0] bwd_reg, bwd_next;
    logic                    ovf_reg, ovf_next;
    logic                    fin_valid_reg, fin_valid_next;
    sums_t                   fin_reg, fin_next;

    logic signed [ACC_W:0]   sum_f, sum_b;
    logic                    of_f, of_b;
    sums_t                   upd;

    assign sum_f = (ACC_W+1)'(fwd_reg) + (ACC_W+1)'(term_f);
    assign sum_b = (ACC_W+1)'(bwd_reg) + (ACC_W+1)'(term_b);
    assign of_f  = sum_f[ACC_W] != sum_f[ACC_W-1];
    assign of_b  = sum_b[ACC_W] != sum_b[ACC_W-1];

    always_comb
    begin
        upd.fwd = fwd_reg;
        upd.bwd = bwd_reg;
        upd.ovf = ovf_reg;
        if (ctl.p_nz && ctl.q_nz)
        begin
            upd.fwd = of_f ? (sum_f[ACC_W] ? ACC_MIN : ACC_MAX) : sum_f[ACC_W-1:0];
            upd.bwd = of_b ? (sum_b[ACC_W] ? ACC_MIN : ACC_MAX) : sum_b[ACC_W-1:0];
            upd.ovf = ovf_reg | of_f | of_b;
        end
        else if (ctl.p_nz)
        begin
            // zero denominator: pin the sum high
            upd.fwd = ACC_MAX;
            upd.ovf = 1'b1;
        end
        else if (ctl.q_nz)
        begin
            upd.bwd = ACC_MAX;
            upd.ovf = 1'b1;
        end
    end

    always_comb
    begin
        fwd_next       = fwd_reg;
        bwd_next       = bwd_reg;
        ovf_next       = ovf_reg;
        fin_next       = fin_reg;
        fin_valid_next = fin_valid_reg & ~fin_take;
        if (adv && ctl.valid)
        begin
            if (ctl.last)
            begin
                fin_next       = upd;
                fin_valid_next = 1'b1;
                fwd_next       = '0;
                bwd_next       = '0;
                ovf_next       = 1'b0;
            end
            else
            begin
                fwd_next = upd.fwd;
                bwd_next = upd.bwd;
                ovf_next = upd.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg       <= '0;
            bwd_reg       <= '0;
            ovf_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_reg       <= fwd_next;
            bwd_reg       <= bwd_next;
            ovf_reg       <= ovf_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

### rtl/core/skla_result.sv
// Clamp of finished sums to Q16.16, averaging and the output word register.
// Depends on skla_pkg and skla_if.
module skla_result import skla_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fin_valid,
    input  sums_t       fin,
    output logic        fin_take,
    skla_out_if.source  result_out
);
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] fwd_reg, fwd_next;
    logic [OUT_W-1:0] bwd_reg, bwd_next;
    logic [OUT_W-1:0] sym_reg, sym_next;
    logic             sat_reg, sat_next;

    logic             hi_f, hi_b;
    logic [OUT_W-1:0] clamp_f, clamp_b;
    logic [OUT_W:0]   pair_sum;

    assign fin_take = fin_valid & ~(out_valid_reg & ~result_out.ready);

    // negative sums drop to zero without raising the flag
    assign hi_f    = ~fin.fwd[ACC_W-1] & (|fin.fwd[ACC_W-2:OUT_W]);
    assign hi_b    = ~fin.bwd[ACC_W-1] & (|fin.bwd[ACC_W-2:OUT_W]);
    assign clamp_f = fin.fwd[ACC_W-1] ? '0 : (hi_f ? '1 : fin.fwd[OUT_W-1:0]);
    assign clamp_b = fin.bwd[ACC_W-1] ? '0 : (hi_b ? '1 : fin.bwd[OUT_W-1:0]);
    assign pair_sum = (OUT_W+1)'(clamp_f) + (OUT_W+1)'(clamp_b);

    always_comb
    begin
        out_valid_next = out_valid_reg & ~result_out.ready;
        fwd_next       = fwd_reg;
        bwd_next       = bwd_reg;
        sym_next       = sym_reg;
        sat_next       = sat_reg;
        if (fin_take)
        begin
            out_valid_next = 1'b1;
            fwd_next       = clamp_f;
            bwd_next       = clamp_b;
            sym_next       = pair_sum[OUT_W:1];
            sat_next       = fin.ovf | hi_f | hi_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        fwd_reg <= fwd_next;
        bwd_reg <= bwd_next;
        sym_reg <= sym_next;
        sat_reg <= sat_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.kl_forward   = fwd_reg;
    assign result_out.kl_backward  = bwd_reg;
    assign result_out.kl_symmetric = sym_reg;
    assign result_out.saturated    = sat_reg;

endmodule

### rtl/core/symmetric_kl_divergence_accumulator.sv
// Last pair word path: input, log, product, hand-off and output registers.
// Throughput: one pair word per cycle through input, log, product and
// accumulate registers; input stalls only while a finished result waits for
// the output register, which is still holding an earlier unread result.
// Reset (rst_n, asynchronous, active low) clears valids, sums and the flag.
// Depends on skla_pkg, skla_if, skla_log2, skla_accum, skla_result.
module symmetric_kl_divergence_accumulator import skla_pkg::*; #(
    parameter int PROB_BITS      = PROB_BITS_DEF,
    parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    skla_in_if.sink    item_in,
    skla_out_if.source result_out
);
    localparam int LOG_W  = log_width(PROB_BITS);
    localparam int DIFF_W = LOG_W + 1;
    localparam int PROD_W = PROB_BITS + 2 + DIFF_W;
    localparam int TERM_W = PROD_W - PROB_BITS;

    logic adv;
    logic fin_valid;
    logic fin_take;
    sums_t fin;

    // stage 1: input register
    stage_ctl_t          ctl1_reg, ctl1_next;
    logic [PROB_BITS:0]  p1_reg, p1_next;
    logic [PROB_BITS:0]  q1_reg, q1_next;

    // stage 2: log differences
    stage_ctl_t               ctl2_reg, ctl2_next;
    logic [PROB_BITS:0]       p2_reg, p2_next;
    logic [PROB_BITS:0]       q2_reg, q2_next;
    logic signed [DIFF_W-1:0] df2_reg, df2_next;
    logic signed [DIFF_W-1:0] db2_reg, db2_next;

    // stage 3: scaled terms
    stage_ctl_t               ctl3_reg, ctl3_next;
    logic signed [TERM_W-1:0] tf3_reg, tf3_next;
    logic signed [TERM_W-1:0] tb3_reg, tb3_next;

    logic signed [LOG_W-1:0]  lp, lq;
    logic signed [PROD_W-1:0] prod_f, prod_b;

    // freeze the pipeline stages and sums while a finished result cannot move on
    assign adv           = ~(fin_valid & ~fin_take);
    assign item_in.ready = adv;

    skla_log2 #(
        .PROB_BITS      (PROB_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_log_p (
        .x       (p1_reg),
        .log_val (lp)
    );

    skla_log2 #(
        .PROB_BITS      (PROB_BITS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_log_q (
        .x       (q1_reg),
        .log_val (lq)
    );

    // arithmetic shift floors toward minus infinity
    assign prod_f = PROD_W'($signed({1'b0, p2_reg})) * PROD_W'(df2_reg);
    assign prod_b = PROD_W'($signed({1'b0, q2_reg})) * PROD_W'(db2_reg);

    always_comb
    begin
        ctl1_next = ctl1_reg;
        p1_next   = p1_reg;
        q1_next   = q1_reg;
        ctl2_next = ctl2_reg;
        p2_next   = p2_reg;
        q2_next   = q2_reg;
        df2_next  = df2_reg;
        db2_next  = db2_reg;
        ctl3_next = ctl3_reg;
        tf3_next  = tf3_reg;
        tb3_next  = tb3_reg;
        if (adv)
        begin
            ctl1_next.valid = item_in.valid;
            ctl1_next.last  = item_in.last_item;
            ctl1_next.p_nz  = 1'b0;
            ctl1_next.q_nz  = 1'b0;
            p1_next         = item_in.p_value;
            q1_next         = item_in.q_value;

            ctl2_next      = ctl1_reg;
            ctl2_next.p_nz = |p1_reg;
            ctl2_next.q_nz = |q1_reg;
            p2_next        = p1_reg;
            q2_next        = q1_reg;
            df2_next       = DIFF_W'(lp) - DIFF_W'(lq);
            db2_next       = DIFF_W'(lq) - DIFF_W'(lp);

            ctl3_next = ctl2_reg;
            tf3_next  = TERM_W'(prod_f >>> PROB_BITS);
            tb3_next  = TERM_W'(prod_b >>> PROB_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl2_next;
            ctl3_reg <= ctl3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= p1_next;
        q1_reg  <= q1_next;
        p2_reg  <= p2_next;
        q2_reg  <= q2_next;
        df2_reg <= df2_next;
        db2_reg <= db2_next;
        tf3_reg <= tf3_next;
        tb3_reg <= tb3_next;
    end

    skla_accum #(
        .TERM_W (TERM_W)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl       (ctl3_reg),
        .term_f    (tf3_reg),
        .term_b    (tb3_reg),
        .fin_take  (fin_take),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    skla_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .fin_valid  (fin_valid),
        .fin        (fin),
        .fin_take   (fin_take),
        .result_out (result_out)
    );

`ifndef SYNTHESIS
    // input held off only when a finished result is blocked by an unread word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_in.ready |-> (fin_valid && result_out.valid && !result_out.ready))
        else $error("input stalled without a blocked result");

    // a last pair leaving the product stage lands in the hand-off register
    a_last_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl3_reg.valid && ctl3_reg.last && adv) |=> fin_valid)
        else $error("last pair produced no finished sums");

    // the average never exceeds the larger divergence
    a_sym_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.kl_symmetric <= result_out.kl_forward
                              || result_out.kl_symmetric <= result_out.kl_backward))
        else $error("symmetric divergence above both halves");
`endif

endmodule
